### sv/iecdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iecdf_pkg: shared types and constants of the integer ECDF engine
// Word layouts of both channels and the sizes that follow from the set depth.
// ----------------------------------------------------------------------------
package iecdf_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_W    = 32;
  localparam int POS_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = POS_W + 1;
  localparam int FRAC_BITS   = 16;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int DIV_STEPS   = CNT_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } sample_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  sample_position;
    logic [CNT_W-1:0]  count_at_or_below;
    logic [FRAC_W-1:0] cumulative_fraction;
    logic              final_result;
  } result_word_t;

endpackage

`default_nettype wire

### sv/integer_ecdf_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_ecdf_engine: empirical CDF over a set of signed 32-bit samples
// Loads a set, then reports count-at-or-below and its Q1.16 fraction for
// every sample in arrival order, using one comparator and one divider step.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the engine is loading; the word with
// last_sample set, or the MAX_SAMPLES-th word, closes the set. The engine
// then stalls its input and reports each sample in turn. For a set of N
// samples each report fetches the sample's key from the sample RAM, walks
// the whole set through the RAM's one read port with the single signed
// comparator, runs the bit-serial restoring divider that forms
// floor(count*2^16/N), and hands the word to the output register. The next
// set may load only once the last report is handed over. The output
// register lets the next report be computed while one waits.
module integer_ecdf_engine
  import iecdf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         sample_valid,
  output logic              sample_stall,
  input  wire sample_word_t sample_word,
  output logic              result_valid,
  input  wire logic         result_stall,
  output result_word_t      result_word
);

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_KEY   = 5'b00010,
    ST_KEYW  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DIV   = 5'b10000
  } state_t;

  state_t state;

  // Sample RAM
  logic signed [SAMPLE_W-1:0] store [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [POS_W-1:0]           rd_addr;

  logic [CNT_W-1:0]           total;
  logic [CNT_W-1:0]           total_p1;
  logic [POS_W-1:0]           outer;
  logic [CNT_W-1:0]           scan;
  logic [CNT_W-1:0]           count;
  logic signed [SAMPLE_W-1:0] key;
  logic [DIV_STEPS-1:0]       div_q;
  logic [CNT_W-1:0]           rem;
  logic [DIV_CNT_W-1:0]       div_cnt;
  logic                       emitting;

  logic                       load_take;
  logic                       closing;
  logic                       hit;
  logic [CNT_W:0]             rem_sh;
  logic                       rem_ge;
  logic                       out_free;
  logic                       last_pos;

  assign sample_stall = (state != ST_LOAD);
  assign load_take    = sample_valid && !sample_stall;
  assign total_p1     = total + 1'b1;
  assign closing      = sample_word.last_sample || (total_p1 == CNT_W'(MAX_SAMPLES));
  assign hit          = (rd_data <= key);
  assign rem_sh       = {rem, div_q[DIV_STEPS-1]};
  assign rem_ge       = (rem_sh >= {1'b0, total});
  assign out_free     = !result_valid || !result_stall;
  assign last_pos     = ({1'b0, outer} + 1'b1) == total;

  // Pick the read address: key fetch, first scan entry, then the walk
  always_comb begin
    case (state)
      ST_KEY:  rd_addr = outer;
      ST_KEYW: rd_addr = '0;
      default: rd_addr = scan[POS_W-1:0];
    endcase
  end

  // Write loaded samples, read one entry a cycle
  always_ff @(posedge clk) begin
    if (load_take) begin
      store[total[POS_W-1:0]] <= sample_word.sample;
    end
    rd_data <= store[rd_addr];
  end

  // Sequencer: load, fetch key, scan, divide, hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      total    <= '0;
      outer    <= '0;
      emitting <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (load_take) begin
            total <= total_p1;
            outer <= '0;
            if (closing) begin
              state <= ST_KEY;
            end
          end
        end
        ST_KEY: begin
          state <= ST_KEYW;
        end
        ST_KEYW: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan == total) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (emitting) begin
            if (out_free) begin
              emitting <= 1'b0;
              if (last_pos) begin
                total <= '0;
                state <= ST_LOAD;
              end else begin
                outer <= outer + 1'b1;
                state <= ST_KEY;
              end
            end
          end else if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            emitting <= 1'b1;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Datapath: key, scan walk, hit count and divider
  always_ff @(posedge clk) begin
    case (state)
      ST_KEYW: begin
        key   <= rd_data;
        scan  <= CNT_W'(1);
        count <= '0;
      end
      ST_SCAN: begin
        count <= count + CNT_W'(hit);
        if (scan != total) begin
          scan <= scan + 1'b1;
        end else begin
          div_q   <= {count + CNT_W'(hit), {FRAC_BITS{1'b0}}};
          rem     <= '0;
          div_cnt <= '0;
        end
      end
      ST_DIV: begin
        if (!emitting) begin
          rem     <= rem_ge ? CNT_W'(rem_sh - {1'b0, total}) : rem_sh[CNT_W-1:0];
          div_q   <= {div_q[DIV_STEPS-2:0], rem_ge};
          div_cnt <= div_cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_DIV) && emitting && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DIV) && emitting && out_free) begin
      result_word.sample_position     <= outer;
      result_word.count_at_or_below   <= count;
      result_word.cumulative_fraction <= div_q[FRAC_W-1:0];
      result_word.final_result        <= last_pos;
    end
  end

  // Checks
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_word.count_at_or_below != '0) &&
                     (result_word.cumulative_fraction != '0) &&
                     (result_word.cumulative_fraction <= FRAC_W'(1 << FRAC_BITS)))
    else $error("report word with empty count or fraction out of range");

  a_full_close: assert property (@(posedge clk) disable iff (rst)
    load_take && (total_p1 == CNT_W'(MAX_SAMPLES)) |=> (state == ST_KEY))
    else $error("full sample store did not close the set");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan <= total) && (total != '0))
    else $error("scan walked past the end of the set");

  a_no_emit_while_loading: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> !emitting)
    else $error("report pending while loading");

endmodule

`default_nettype wire
